/* rtl/core/mrwt_pkg.sv */
// Package for the Miller-Rabin witness test block.
// Holds the fixed field widths and the sequencer state codes; no dependencies.
`default_nettype none

package mrwt_pkg;

	// Width of the candidate and witness_base ports
	localparam int FIELD_WIDTH = 32;

	// Sequencer state codes
	localparam int ST_WIDTH = 4;
	localparam logic [ST_WIDTH-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_WIDTH-1:0] ST_SHIFT = 4'd1;
	localparam logic [ST_WIDTH-1:0] ST_RED   = 4'd2;
	localparam logic [ST_WIDTH-1:0] ST_POW   = 4'd3;
	localparam logic [ST_WIDTH-1:0] ST_PMUL  = 4'd4;
	localparam logic [ST_WIDTH-1:0] ST_PSQR  = 4'd5;
	localparam logic [ST_WIDTH-1:0] ST_CHK   = 4'd6;
	localparam logic [ST_WIDTH-1:0] ST_LOOP  = 4'd7;
	localparam logic [ST_WIDTH-1:0] ST_LSQ   = 4'd8;
	localparam logic [ST_WIDTH-1:0] ST_DONE  = 4'd9;

endpackage

`default_nettype wire

/* rtl/core/miller_rabin_witness_test_top.sv */
// Top level of the Miller-Rabin witness test: sequencer plus a shared
// bit-serial modular multiplier. Depends on mrwt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat: candidate n and
//   witness_base a, taken in their low NUM_WIDTH bits. Output channel
//   (out_valid/out_ready) returns one beat per input: probably_prime and
//   decided_without_base.
//   Small or even candidates (n < 4 or n even) are decided at once: the
//   sequencer goes straight to ST_DONE and loads the result into the output
//   register, then returns to ST_IDLE, where the next input beat can follow.
//   Every other candidate runs through one shared modular multiplier that
//   consumes one multiplier bit per cycle. A test needs one product to
//   reduce the base, a square for every bit of d plus a multiply for every
//   set bit, and up to r-1 more squarings. The most products are needed for
//   n = 2^NUM_WIDTH - 1 (r = 1, d all ones). One item is in work at a time,
//   so the next input beat is taken in the cycle after the result leaves the
//   sequencer, even while it still waits in the output register. If the
//   receiver stalls, a finished result holds in the sequencer, and the input
//   with it, until the output register frees up.
//   Reset (arst_n low) drops any item in work and clears out_valid.
`default_nettype none

module miller_rabin_witness_test_top #(
	parameter int NUM_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [mrwt_pkg::FIELD_WIDTH-1:0]  candidate,
	input  wire logic [mrwt_pkg::FIELD_WIDTH-1:0]  witness_base,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic                              probably_prime,
	output      logic                              decided_without_base
);

	localparam int CNT_W = $clog2(NUM_WIDTH + 1);
	localparam int SUM_W = NUM_WIDTH + 2;

	// Operands cut or widened to NUM_WIDTH
	logic [NUM_WIDTH-1:0] n_in;
	logic [NUM_WIDTH-1:0] a_in;

	if (NUM_WIDTH <= mrwt_pkg::FIELD_WIDTH) begin : g_trunc
		assign n_in = candidate[NUM_WIDTH-1:0];
		assign a_in = witness_base[NUM_WIDTH-1:0];
	end else begin : g_ext
		assign n_in = {{(NUM_WIDTH - mrwt_pkg::FIELD_WIDTH){1'b0}}, candidate};
		assign a_in = {{(NUM_WIDTH - mrwt_pkg::FIELD_WIDTH){1'b0}}, witness_base};
	end

	// Sequencer registers
	logic [mrwt_pkg::ST_WIDTH-1:0] state_q;
	logic [NUM_WIDTH-1:0]          n_q;      // modulus
	logic [NUM_WIDTH-1:0]          last_q;   // n - 1
	logic [NUM_WIDTH-1:0]          a_q;      // raw base
	logic [NUM_WIDTH-1:0]          e_q;      // exponent, shifts right
	logic [NUM_WIDTH-1:0]          b_q;      // running power of the base
	logic [NUM_WIDTH-1:0]          x_q;      // running result
	logic [CNT_W-1:0]              r_q;      // remaining squarings count
	logic                          res_pp_q;
	logic                          res_dwb_q;

	// Output register
	logic out_valid_q;
	logic out_pp_q;
	logic out_dwb_q;

	// Shared bit-serial multiplier: acc = acc*2 + bit*mx mod n, MSB of my first
	logic                 mul_busy_q;
	logic [CNT_W-1:0]     mcnt_q;
	logic [NUM_WIDTH-1:0] mx_q;
	logic [NUM_WIDTH-1:0] my_q;
	logic [NUM_WIDTH-1:0] acc_q;

	logic                 mul_start;
	logic [NUM_WIDTH-1:0] mul_x;
	logic [NUM_WIDTH-1:0] mul_y;

	logic [SUM_W-1:0] step_sum;
	logic [SUM_W-1:0] mod1;
	logic [SUM_W-1:0] mod2;
	logic [SUM_W-1:0] step_red;

	always_comb begin
		mod1     = {2'b00, n_q};
		mod2     = {1'b0, n_q, 1'b0};
		step_sum = {1'b0, acc_q, 1'b0}
			+ (my_q[NUM_WIDTH-1] ? {2'b00, mx_q} : {SUM_W{1'b0}});
		// step_sum < 3n: subtract 0, n or 2n
		if (step_sum >= mod2) begin
			step_red = step_sum - mod2;
		end else if (step_sum >= mod1) begin
			step_red = step_sum - mod1;
		end else begin
			step_red = step_sum;
		end
	end

	wire in_fire  = in_valid && in_ready;
	wire out_free = !out_valid_q || out_ready;
	wire n_small  = (n_in[NUM_WIDTH-1:2] == '0) || !n_in[0];

	assign in_ready = (state_q == mrwt_pkg::ST_IDLE);

	// Multiplier launch requests from the sequencer
	always_comb begin
		mul_start = 1'b0;
		mul_x     = b_q;
		mul_y     = b_q;
		case (state_q)
			mrwt_pkg::ST_SHIFT: begin
				// a mod n as Horner over the bits of a: 1 * a mod n
				if (e_q[0]) begin
					mul_start = 1'b1;
					mul_x     = {{(NUM_WIDTH-1){1'b0}}, 1'b1};
					mul_y     = a_q;
				end
			end
			mrwt_pkg::ST_POW: begin
				if (e_q != '0) begin
					mul_start = 1'b1;
					if (e_q[0]) begin
						mul_x = x_q;
					end
				end
			end
			mrwt_pkg::ST_PMUL: begin
				mul_start = !mul_busy_q;
			end
			mrwt_pkg::ST_LOOP: begin
				if (r_q > CNT_W'(1)) begin
					mul_start = 1'b1;
					mul_x     = x_q;
					mul_y     = x_q;
				end
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Multiplier datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mcnt_q     <= '0;
		end else if (mul_start) begin
			mul_busy_q <= 1'b1;
			mcnt_q     <= CNT_W'(NUM_WIDTH);
		end else if (mul_busy_q) begin
			mcnt_q     <= mcnt_q - CNT_W'(1);
			mul_busy_q <= (mcnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			mx_q  <= mul_x;
			my_q  <= mul_y;
			acc_q <= '0;
		end else if (mul_busy_q) begin
			acc_q <= step_red[NUM_WIDTH-1:0];
			my_q  <= {my_q[NUM_WIDTH-2:0], 1'b0};
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrwt_pkg::ST_IDLE;
		end else begin
			case (state_q)
				mrwt_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= n_small ? mrwt_pkg::ST_DONE : mrwt_pkg::ST_SHIFT;
					end
				end
				mrwt_pkg::ST_SHIFT: begin
					if (e_q[0]) begin
						state_q <= mrwt_pkg::ST_RED;
					end
				end
				mrwt_pkg::ST_RED: begin
					if (!mul_busy_q) begin
						state_q <= mrwt_pkg::ST_POW;
					end
				end
				mrwt_pkg::ST_POW: begin
					if (e_q == '0) begin
						state_q <= mrwt_pkg::ST_CHK;
					end else if (e_q[0]) begin
						state_q <= mrwt_pkg::ST_PMUL;
					end else begin
						state_q <= mrwt_pkg::ST_PSQR;
					end
				end
				mrwt_pkg::ST_PMUL: begin
					if (!mul_busy_q) begin
						state_q <= mrwt_pkg::ST_PSQR;
					end
				end
				mrwt_pkg::ST_PSQR: begin
					if (!mul_busy_q) begin
						state_q <= mrwt_pkg::ST_POW;
					end
				end
				mrwt_pkg::ST_CHK: begin
					if (x_q == {{(NUM_WIDTH-1){1'b0}}, 1'b1} || x_q == last_q) begin
						state_q <= mrwt_pkg::ST_DONE;
					end else begin
						state_q <= mrwt_pkg::ST_LOOP;
					end
				end
				mrwt_pkg::ST_LOOP: begin
					state_q <= (r_q > CNT_W'(1)) ? mrwt_pkg::ST_LSQ : mrwt_pkg::ST_DONE;
				end
				mrwt_pkg::ST_LSQ: begin
					if (!mul_busy_q) begin
						state_q <= (acc_q == last_q) ? mrwt_pkg::ST_DONE
							: mrwt_pkg::ST_LOOP;
					end
				end
				mrwt_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mrwt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mrwt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mrwt_pkg::ST_IDLE: begin
				n_q       <= n_in;
				last_q    <= n_in - NUM_WIDTH'(1);
				e_q       <= n_in - NUM_WIDTH'(1);
				a_q       <= a_in;
				r_q       <= '0;
				res_pp_q  <= (n_in == NUM_WIDTH'(2)) || (n_in == NUM_WIDTH'(3));
				res_dwb_q <= 1'b1;
			end
			mrwt_pkg::ST_SHIFT: begin
				// strip factors of two from n - 1
				res_dwb_q <= 1'b0;
				if (!e_q[0]) begin
					e_q <= {1'b0, e_q[NUM_WIDTH-1:1]};
					r_q <= r_q + CNT_W'(1);
				end
			end
			mrwt_pkg::ST_RED: begin
				if (!mul_busy_q) begin
					b_q <= acc_q;
					x_q <= {{(NUM_WIDTH-1){1'b0}}, 1'b1};
				end
			end
			mrwt_pkg::ST_PMUL: begin
				if (!mul_busy_q) begin
					x_q <= acc_q;
				end
			end
			mrwt_pkg::ST_PSQR: begin
				if (!mul_busy_q) begin
					b_q <= acc_q;
					e_q <= {1'b0, e_q[NUM_WIDTH-1:1]};
				end
			end
			mrwt_pkg::ST_CHK: begin
				res_pp_q <= (x_q == {{(NUM_WIDTH-1){1'b0}}, 1'b1}) || (x_q == last_q);
			end
			mrwt_pkg::ST_LOOP: begin
				if (r_q > CNT_W'(1)) begin
					r_q <= r_q - CNT_W'(1);
				end
			end
			mrwt_pkg::ST_LSQ: begin
				if (!mul_busy_q) begin
					x_q      <= acc_q;
					res_pp_q <= (acc_q == last_q);
				end
			end
			default: begin
				res_pp_q <= res_pp_q;
			end
		endcase
	end

	// Output register: load from the sequencer, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mrwt_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mrwt_pkg::ST_DONE && out_free) begin
			out_pp_q  <= res_pp_q;
			out_dwb_q <= res_dwb_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign probably_prime       = out_pp_q;
	assign decided_without_base = out_dwb_q;

endmodule

`default_nettype wire
